// ----- hdl/dhs_pkg.sv -----
// ----------------------------------------------------------------------------
// Disk head seek scheduler package
// Shared constants, codes, item types and inter-module structs.
// ----------------------------------------------------------------------------
package dhs_pkg;

  // Sizing of the request store and the cylinder range.
  localparam int MAX_REQUESTS = 16;
  localparam int CYL_BITS     = 16;
  localparam int CYL_MAX      = (1 << CYL_BITS) - 1;

  // Derived widths.
  localparam int CNT_W  = $clog2(MAX_REQUESTS + 1);
  localparam int IDX_W  = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int TOT_W  = $clog2(MAX_REQUESTS + 4);
  localparam int SEEK_W = 22;

  // Configuration port geometry and reset values.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam logic [16:0] DISK_SIZE_RST = 17'd200;

  typedef logic [CYL_BITS-1:0] cyl_t;

  // Input command codes.
  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  // Scheduling policy codes.
  typedef enum logic [1:0] {
    POL_FCFS  = 2'd0,
    POL_SCAN  = 2'd1,
    POL_CSCAN = 2'd2
  } policy_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DISK_SIZE  = 2'd0,
    REG_START_POS  = 2'd1,
    REG_POLICY     = 2'd2,
    REG_SWEEP_DOWN = 2'd3
  } cfg_reg_t;

  // Run sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETTLE,
    ST_SPLIT,
    ST_START,
    ST_GRP_A,
    ST_EDGE1,
    ST_EDGE2,
    ST_GRP_B
  } seq_state_t;

  // Channel payloads.
  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] cylinder;
  } in_item_t;

  typedef struct packed {
    logic [15:0]       head_stop;
    logic [SEEK_W-1:0] seek_total;
    logic              last_stop;
  } out_item_t;

  // Value travelling between neighboring sort cells.
  typedef struct packed {
    logic vld;
    cyl_t val;
  } carry_t;

  // Control from the top level and sequencer into the cell row.
  typedef struct packed {
    logic             load;
    logic             clear;
    cyl_t             cyl;
    cyl_t             start;
    logic [IDX_W-1:0] rd_idx;
  } chain_ctl_t;

  // Status and read data from the cell row.
  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] split;
    cyl_t             arr_rd;
    cyl_t             srt_rd;
  } chain_stat_t;

  // Decoded run configuration for the sequencer.
  typedef struct packed {
    cyl_t start;
    cyl_t top;
    logic sorted;
    logic cscan;
    logic down;
  } seq_cfg_t;

endpackage

// ----- hdl/dhs_cell.sv -----
// ----------------------------------------------------------------------------
// Disk head seek scheduler cell
// Holds one arrival-order request and one slot of the systolic insertion
// sorter; keeps the smaller value and passes the larger one to its neighbor.
// ----------------------------------------------------------------------------
module dhs_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            clear,
  input  logic            arr_we,
  input  dhs_pkg::cyl_t   arr_wdata,
  input  dhs_pkg::carry_t carry_in,
  output dhs_pkg::carry_t carry_out,
  output logic            srt_vld,
  output dhs_pkg::cyl_t   srt_val,
  output dhs_pkg::cyl_t   arr_val
);

  logic          srt_vld_r, srt_vld_nxt;
  dhs_pkg::cyl_t srt_val_r, srt_val_nxt;
  logic          carry_vld_r, carry_vld_nxt;
  dhs_pkg::cyl_t carry_val_r, carry_val_nxt;
  dhs_pkg::cyl_t arr_val_r, arr_val_nxt;

  // Insertion step: an empty slot takes the value, a full one keeps the minimum.
  always_comb begin
    srt_vld_nxt   = srt_vld_r;
    srt_val_nxt   = srt_val_r;
    carry_vld_nxt = 1'b0;
    carry_val_nxt = carry_val_r;
    if (clear) begin
      srt_vld_nxt = 1'b0;
    end else if (carry_in.vld) begin
      if (!srt_vld_r) begin
        srt_vld_nxt = 1'b1;
        srt_val_nxt = carry_in.val;
      end else if (carry_in.val < srt_val_r) begin
        srt_val_nxt   = carry_in.val;
        carry_vld_nxt = 1'b1;
        carry_val_nxt = srt_val_r;
      end else begin
        carry_vld_nxt = 1'b1;
        carry_val_nxt = carry_in.val;
      end
    end
  end

  // Arrival-order slot is written once per load that lands here.
  always_comb begin
    arr_val_nxt = arr_we ? arr_wdata : arr_val_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srt_vld_r   <= 1'b0;
      carry_vld_r <= 1'b0;
    end else begin
      srt_vld_r   <= srt_vld_nxt;
      carry_vld_r <= carry_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    srt_val_r   <= srt_val_nxt;
    carry_val_r <= carry_val_nxt;
    arr_val_r   <= arr_val_nxt;
  end

  assign carry_out.vld = carry_vld_r;
  assign carry_out.val = carry_val_r;
  assign srt_vld       = srt_vld_r;
  assign srt_val       = srt_val_r;
  assign arr_val       = arr_val_r;

endmodule

// ----- hdl/dhs_chain.sv -----
// ----------------------------------------------------------------------------
// Disk head seek scheduler cell row
// A row of sort cells fed one request per cycle, the request counter, the
// split count against the start cylinder and the read selection.
// ----------------------------------------------------------------------------
module dhs_chain (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dhs_pkg::chain_ctl_t  ctl,
  output dhs_pkg::chain_stat_t stat
);

  logic [dhs_pkg::CNT_W-1:0]        count_r, count_nxt;
  logic                             load_ok;
  dhs_pkg::carry_t                  link [dhs_pkg::MAX_REQUESTS+1];
  logic [dhs_pkg::MAX_REQUESTS-1:0] srt_vld;
  dhs_pkg::cyl_t                    srt_val [dhs_pkg::MAX_REQUESTS];
  dhs_pkg::cyl_t                    arr_val [dhs_pkg::MAX_REQUESTS];
  logic [dhs_pkg::MAX_REQUESTS-1:0] at_or_below;
  logic [dhs_pkg::MAX_REQUESTS-1:0] carry_busy;
  logic [dhs_pkg::MAX_REQUESTS-1:0] order_ok;

  // A load into a full store is dropped before it reaches the row.
  assign load_ok = ctl.load && (count_r < dhs_pkg::CNT_W'(dhs_pkg::MAX_REQUESTS));

  assign link[0].vld = load_ok;
  assign link[0].val = ctl.cyl;

  // The row of cells.
  for (genvar g = 0; g < dhs_pkg::MAX_REQUESTS; g++) begin : g_cell
    dhs_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .clear     (ctl.clear),
      .arr_we    (load_ok && (count_r == dhs_pkg::CNT_W'(g))),
      .arr_wdata (ctl.cyl),
      .carry_in  (link[g]),
      .carry_out (link[g+1]),
      .srt_vld   (srt_vld[g]),
      .srt_val   (srt_val[g]),
      .arr_val   (arr_val[g])
    );

    assign at_or_below[g] = srt_vld[g] && (srt_val[g] <= ctl.start);
    assign carry_busy[g]  = link[g+1].vld;
  end

  // Neighboring sorted slots must be ascending and packed toward cell zero.
  for (genvar g = 0; g < dhs_pkg::MAX_REQUESTS - 1; g++) begin : g_order
    assign order_ok[g] = !srt_vld[g+1] || (srt_vld[g] && (srt_val[g] <= srt_val[g+1]));
  end
  assign order_ok[dhs_pkg::MAX_REQUESTS-1] = 1'b1;

  // Request counter.
  always_comb begin
    count_nxt = count_r;
    if (ctl.clear) begin
      count_nxt = '0;
    end else if (load_ok) begin
      count_nxt = count_r + dhs_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Status and read data toward the sequencer.
  assign stat.busy   = |carry_busy;
  assign stat.count  = count_r;
  assign stat.split  = dhs_pkg::CNT_W'($countones(at_or_below));
  assign stat.arr_rd = arr_val[ctl.rd_idx];
  assign stat.srt_rd = srt_val[ctl.rd_idx];

  a_sorted_when_settled: assert property (@(posedge clk) disable iff (!rst_n)
    !stat.busy |-> &order_ok)
    else $error("sort row out of order after settling");

  a_count_matches_row: assert property (@(posedge clk) disable iff (!rst_n)
    !stat.busy |-> ($countones(srt_vld) == int'(count_r)))
    else $error("request count disagrees with occupied sort cells");

endmodule

// ----- hdl/dhs_sequencer.sv -----
// ----------------------------------------------------------------------------
// Disk head seek scheduler run sequencer
// Walks the head stops of one run, accumulates the seek total and drives the
// registered result item.
// ----------------------------------------------------------------------------
module dhs_sequencer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       run_start,
  input  dhs_pkg::seq_cfg_t          cfg,
  input  dhs_pkg::chain_stat_t       stat,
  output logic [dhs_pkg::IDX_W-1:0]  rd_idx,
  output logic                       idle,
  output logic                       out_valid,
  input  logic                       out_stall,
  output dhs_pkg::out_item_t         out_item
);

  dhs_pkg::seq_state_t                 state_r, state_nxt;
  logic [dhs_pkg::CNT_W-1:0]           idx_r, idx_nxt;
  logic [dhs_pkg::CNT_W-1:0]           rem_r, rem_nxt;
  logic                                dir_r, dir_nxt;
  logic [dhs_pkg::CNT_W-1:0]           split_r, split_nxt;
  dhs_pkg::cyl_t                       head_r, head_nxt;
  logic [dhs_pkg::SEEK_W-1:0]          total_r, total_nxt;
  logic [dhs_pkg::TOT_W-1:0]           tot_r, tot_nxt;
  dhs_pkg::out_item_t                  out_r, out_nxt;
  logic                                out_valid_r, out_valid_nxt;

  logic                                fire;
  logic                                emit;
  logic                                grp_done;
  logic [dhs_pkg::CNT_W-1:0]           n;
  logic [dhs_pkg::CNT_W-1:0]           a_idx, a_rem, b_idx, b_rem;
  logic                                a_dir, b_dir;
  dhs_pkg::cyl_t                       pos;
  dhs_pkg::cyl_t                       diff;
  logic [dhs_pkg::SEEK_W-1:0]          sum;

  // The output register can take a new item when empty or being drained.
  assign fire = !out_valid_r || !out_stall;
  assign n    = stat.count;

  always_comb begin
    emit = 1'b0;
    case (state_r)
      dhs_pkg::ST_START, dhs_pkg::ST_EDGE1, dhs_pkg::ST_EDGE2: begin
        emit = fire;
      end
      dhs_pkg::ST_GRP_A, dhs_pkg::ST_GRP_B: begin
        emit = fire && (rem_r != '0);
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign grp_done = (rem_r == '0) || (fire && (rem_r == dhs_pkg::CNT_W'(1)));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dhs_pkg::ST_IDLE: begin
        if (run_start) state_nxt = dhs_pkg::ST_SETTLE;
      end
      dhs_pkg::ST_SETTLE: begin
        if (!stat.busy) state_nxt = dhs_pkg::ST_SPLIT;
      end
      dhs_pkg::ST_SPLIT: begin
        state_nxt = dhs_pkg::ST_START;
      end
      dhs_pkg::ST_START: begin
        if (fire) state_nxt = dhs_pkg::ST_GRP_A;
      end
      dhs_pkg::ST_GRP_A: begin
        if (grp_done) state_nxt = cfg.sorted ? dhs_pkg::ST_EDGE1 : dhs_pkg::ST_IDLE;
      end
      dhs_pkg::ST_EDGE1: begin
        if (fire) state_nxt = cfg.cscan ? dhs_pkg::ST_EDGE2 : dhs_pkg::ST_GRP_B;
      end
      dhs_pkg::ST_EDGE2: begin
        if (fire) state_nxt = dhs_pkg::ST_GRP_B;
      end
      dhs_pkg::ST_GRP_B: begin
        if (grp_done) state_nxt = dhs_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = dhs_pkg::ST_IDLE;
      end
    endcase
  end

  // First group: arrival order, or the requests on the sweep side of the head.
  always_comb begin
    if (!cfg.sorted) begin
      a_idx = '0;
      a_rem = n;
      a_dir = 1'b0;
    end else if (!cfg.down) begin
      a_idx = split_r;
      a_rem = n - split_r;
      a_dir = 1'b0;
    end else begin
      a_idx = split_r - dhs_pkg::CNT_W'(1);
      a_rem = split_r;
      a_dir = 1'b1;
    end
  end

  // Second group: the requests left behind, walked back or wrapped around.
  always_comb begin
    if (!cfg.down && !cfg.cscan) begin
      b_idx = split_r - dhs_pkg::CNT_W'(1);
      b_rem = split_r;
      b_dir = 1'b1;
    end else if (!cfg.down) begin
      b_idx = '0;
      b_rem = split_r;
      b_dir = 1'b0;
    end else if (!cfg.cscan) begin
      b_idx = split_r;
      b_rem = n - split_r;
      b_dir = 1'b0;
    end else begin
      b_idx = n - dhs_pkg::CNT_W'(1);
      b_rem = n - split_r;
      b_dir = 1'b1;
    end
  end

  // Cylinder of the stop offered in this cycle.
  always_comb begin
    case (state_r)
      dhs_pkg::ST_START: pos = cfg.start;
      dhs_pkg::ST_GRP_A: pos = cfg.sorted ? stat.srt_rd : stat.arr_rd;
      dhs_pkg::ST_EDGE1: pos = cfg.down ? '0 : cfg.top;
      dhs_pkg::ST_EDGE2: pos = cfg.down ? cfg.top : '0;
      dhs_pkg::ST_GRP_B: pos = stat.srt_rd;
      default:           pos = cfg.start;
    endcase
  end

  // Head movement for this stop.
  assign diff = (pos > head_r) ? (pos - head_r) : (head_r - pos);
  assign sum  = total_r + dhs_pkg::SEEK_W'(diff);

  // Datapath and result register.
  always_comb begin
    idx_nxt       = idx_r;
    rem_nxt       = rem_r;
    dir_nxt       = dir_r;
    split_nxt     = split_r;
    head_nxt      = head_r;
    total_nxt     = total_r;
    tot_nxt       = tot_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;

    if (state_r == dhs_pkg::ST_SPLIT) begin
      split_nxt = stat.split;
      head_nxt  = cfg.start;
      total_nxt = '0;
      tot_nxt   = dhs_pkg::TOT_W'(n) + dhs_pkg::TOT_W'(1)
                + (cfg.sorted ? dhs_pkg::TOT_W'(1) : '0)
                + (cfg.cscan ? dhs_pkg::TOT_W'(1) : '0);
    end

    if (emit) begin
      head_nxt           = pos;
      total_nxt          = sum;
      tot_nxt            = tot_r - dhs_pkg::TOT_W'(1);
      out_nxt.head_stop  = 16'(pos);
      out_nxt.seek_total = sum;
      out_nxt.last_stop  = (tot_r == dhs_pkg::TOT_W'(1));
      out_valid_nxt      = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // Group walking and group setup.
    if (emit && ((state_r == dhs_pkg::ST_GRP_A) || (state_r == dhs_pkg::ST_GRP_B))) begin
      idx_nxt = dir_r ? (idx_r - dhs_pkg::CNT_W'(1)) : (idx_r + dhs_pkg::CNT_W'(1));
      rem_nxt = rem_r - dhs_pkg::CNT_W'(1);
    end else if (fire && (state_r == dhs_pkg::ST_START)) begin
      idx_nxt = a_idx;
      rem_nxt = a_rem;
      dir_nxt = a_dir;
    end else if (fire && (((state_r == dhs_pkg::ST_EDGE1) && !cfg.cscan) ||
                          (state_r == dhs_pkg::ST_EDGE2))) begin
      idx_nxt = b_idx;
      rem_nxt = b_rem;
      dir_nxt = b_dir;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dhs_pkg::ST_IDLE;
      tot_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tot_r       <= tot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    rem_r   <= rem_nxt;
    dir_r   <= dir_nxt;
    split_r <= split_nxt;
    head_r  <= head_nxt;
    total_r <= total_nxt;
    out_r   <= out_nxt;
  end

  assign rd_idx    = idx_r[dhs_pkg::IDX_W-1:0];
  assign idle      = (state_r == dhs_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_emit_has_budget: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (tot_r != '0))
    else $error("stop emitted beyond the planned stop count");

  a_idle_all_emitted: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dhs_pkg::ST_IDLE) |-> (tot_r == '0))
    else $error("run finished with stops still pending");

endmodule

// ----- hdl/disk_head_seek_scheduler.sv -----
// ----------------------------------------------------------------------------
// Disk head seek scheduler
// Load and clear items are accepted back to back while no run is active.
// A run item waits in the settle state until the sort row drains, passes the
// split state, then emits one stop per cycle (n+1 to n+3 stops); an empty
// request group emits no stop, and output stall holds the sequencer.
// Synchronous active-low reset clears the request count, cell valids, the
// sequencer and output valid, and returns the registers to their defaults.
// ----------------------------------------------------------------------------
module disk_head_seek_scheduler (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  dhs_pkg::in_item_t                 in_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output dhs_pkg::out_item_t                out_item,
  input  logic                              cfg_we,
  input  logic [dhs_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [dhs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic [16:0]          disk_size_r, disk_size_nxt;
  logic [15:0]          start_pos_r, start_pos_nxt;
  logic [1:0]           policy_r, policy_nxt;
  logic                 sweep_down_r, sweep_down_nxt;

  logic                 accept;
  logic                 seq_idle;
  logic [16:0]          size_m1;
  dhs_pkg::chain_ctl_t  ctl;
  dhs_pkg::chain_stat_t stat;
  dhs_pkg::seq_cfg_t    scfg;
  logic [dhs_pkg::IDX_W-1:0] rd_idx;

  // Configuration registers.
  always_comb begin
    disk_size_nxt  = disk_size_r;
    start_pos_nxt  = start_pos_r;
    policy_nxt     = policy_r;
    sweep_down_nxt = sweep_down_r;
    if (cfg_we) begin
      case (cfg_idx)
        dhs_pkg::REG_DISK_SIZE:  disk_size_nxt  = cfg_wdata[16:0];
        dhs_pkg::REG_START_POS:  start_pos_nxt  = cfg_wdata[15:0];
        dhs_pkg::REG_POLICY:     policy_nxt     = cfg_wdata[1:0];
        dhs_pkg::REG_SWEEP_DOWN: sweep_down_nxt = cfg_wdata[0];
        default: begin
          disk_size_nxt = disk_size_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disk_size_r  <= dhs_pkg::DISK_SIZE_RST;
      start_pos_r  <= '0;
      policy_r     <= dhs_pkg::POL_FCFS;
      sweep_down_r <= 1'b0;
    end else begin
      disk_size_r  <= disk_size_nxt;
      start_pos_r  <= start_pos_nxt;
      policy_r     <= policy_nxt;
      sweep_down_r <= sweep_down_nxt;
    end
  end

  // Top edge is the size minus one, saturated to the cylinder range.
  assign size_m1 = disk_size_r - 17'd1;

  always_comb begin
    scfg.start  = start_pos_r[dhs_pkg::CYL_BITS-1:0];
    scfg.sorted = policy_r inside {dhs_pkg::POL_SCAN, dhs_pkg::POL_CSCAN};
    scfg.cscan  = (policy_r == dhs_pkg::POL_CSCAN);
    scfg.down   = sweep_down_r;
    if (disk_size_r == '0) begin
      scfg.top = '0;
    end else if (size_m1 > 17'(dhs_pkg::CYL_MAX)) begin
      scfg.top = dhs_pkg::cyl_t'(dhs_pkg::CYL_MAX);
    end else begin
      scfg.top = size_m1[dhs_pkg::CYL_BITS-1:0];
    end
  end

  // Input handshake and command decode.
  assign in_stall = !seq_idle;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    ctl.load   = accept && (in_item.command == dhs_pkg::CMD_LOAD);
    ctl.clear  = accept && (in_item.command == dhs_pkg::CMD_CLEAR);
    ctl.cyl    = in_item.cylinder[dhs_pkg::CYL_BITS-1:0];
    ctl.start  = start_pos_r[dhs_pkg::CYL_BITS-1:0];
    ctl.rd_idx = rd_idx;
  end

  dhs_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .stat  (stat)
  );

  dhs_sequencer u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .run_start (accept && (in_item.command == dhs_pkg::CMD_RUN)),
    .cfg       (scfg),
    .stat      (stat),
    .rd_idx    (rd_idx),
    .idle      (seq_idle),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
